### rtl/clc_pkg.sv
package clc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_LIGHT = 2'd0,
    CMD_BOX_MIN    = 2'd1,
    CMD_CULL       = 2'd2,
    CMD_FRAME      = 2'd3
  } cmd_e;

  localparam logic RES_INDEX   = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  localparam int CoordW  = 32;
  localparam int RadiusW = 31;
  localparam int OffsetW = 24;
  localparam int CountW  = 7;
  localparam int SlotW   = 6;
  localparam int TotalW  = 6;
  localparam logic [OffsetW-1:0] OffsetMax = '1;

  localparam int InTdataW  = 144;
  localparam int OutTdataW = 40;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_AXIS  = 6'b000100,
    ST_TEST  = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_SUM   = 6'b100000
  } state_e;

endpackage

### rtl/cluster_light_culler.sv
// Channel  | Dir | Payload
// s_axis   | in  | tdata: command, light_slot, coord_x/y/z, light_radius, light_kind
// m_axis   | out | tdata: visible_light, list_offset, cluster_light_total;
//          |     | tuser: result_kind; tlast: last
// cfg      | in  | light_count, written when cfg_we_i is high
// Load, box-min and frame commands are accepted every cycle while idle and emit nothing.
// A cull holds s_axis_tready low while, for each tested light, it does a table read, three
// axis squares and the range square on one shared 32x32 multiplier, and a compare, plus an
// emit step per emitted index, then a table read and the summary; m_axis stalls lengthen
// it. Reset clears control state, the box minimum, the offset and light_count; the light
// table is not cleared.
module cluster_light_culler
  import clc_pkg::*;
#(
  parameter int MAX_LIGHTS      = 64,
  parameter int MAX_PER_CLUSTER = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] command, [7:2] light_slot, [39:8] coord_x, [71:40] coord_y,
  // [103:72] coord_z, [134:104] light_radius, [142:135] light_kind (zero pad)
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [5:0] visible_light, [29:6] list_offset, [35:30] cluster_light_total
  output logic [OutTdataW-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i
);

  localparam int AddrW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int IdxW  = $clog2(MAX_LIGHTS + 1);

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadiusW-1:0]       r;
    logic                     dir;
  } light_t;

  light_t mem_q [MAX_LIGHTS];
  light_t rd_q;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q;
  logic signed [CoordW-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
  logic [OffsetW-1:0] off_q;
  logic [IdxW-1:0] idx_q, limit_q;
  logic [TotalW-1:0] cnt_q;
  logic [1:0] axis_q;
  logic [64:0] acc_q;
  logic [63:0] rr_q;

  logic [1:0]          cmd;
  logic [SlotW-1:0]    slot;
  logic signed [CoordW-1:0] ix, iy, iz;
  assign cmd  = s_axis_tdata[1:0];
  assign slot = s_axis_tdata[7:2];
  assign ix   = s_axis_tdata[39:8];
  assign iy   = s_axis_tdata[71:40];
  assign iz   = s_axis_tdata[103:72];

  assign s_axis_tready = (state_q == ST_IDLE);
  logic in_xfer, out_xfer;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // shared unit: clamp, abs, square; last step squares the range
  logic signed [CoordW-1:0] p, lo, hi, c;
  logic signed [CoordW:0] d;
  logic [CoordW-1:0] a;
  logic [CoordW-1:0] m_op;
  logic [63:0] sq;
  logic [64:0] sum;
  always_comb begin
    unique case (axis_q)
      2'd0:    begin p = rd_q.x; lo = min_x_q; hi = max_x_q; end
      2'd1:    begin p = rd_q.y; lo = min_y_q; hi = max_y_q; end
      default: begin p = rd_q.z; lo = min_z_q; hi = max_z_q; end
    endcase
    c = p;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    d = {p[CoordW-1], p} - {c[CoordW-1], c};
    a = d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    m_op = (axis_q == 2'd3) ? {1'b0, rd_q.r} : a;
    sq = 64'(m_op) * 64'(m_op);
    sum = acc_q + {1'b0, sq};
  end

  logic vis;
  assign vis = rd_q.dir || (acc_q[64] == 1'b0 && acc_q[63:0] <= rr_q);

  logic [OffsetW:0] off_sum;
  assign off_sum = {1'b0, off_q} + (OffsetW+1)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd == CMD_LOAD_LIGHT && 32'(slot) < MAX_LIGHTS) begin
      mem_q[AddrW'(slot)] <= '{x: ix, y: iy, z: iz,
                               r: s_axis_tdata[134:104],
                               dir: (s_axis_tdata[142:135] == 8'd0)};
    end
    if (state_q == ST_READ) rd_q <= mem_q[idx_q[AddrW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer && cmd == CMD_CULL) state_d = ST_READ;
      ST_READ: state_d = (idx_q < limit_q) ? ST_AXIS : ST_SUM;
      ST_AXIS: if (axis_q == 2'd3) state_d = ST_TEST;
      ST_TEST: state_d = (vis && 32'(cnt_q) < MAX_PER_CLUSTER) ? ST_EMIT : ST_READ;
      ST_EMIT: if (out_xfer) state_d = ST_READ;
      ST_SUM:  if (out_xfer) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      min_x_q <= '0; min_y_q <= '0; min_z_q <= '0;
      off_q   <= '0;
      idx_q   <= '0; limit_q <= '0; cnt_q <= '0; axis_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (in_xfer) begin
        unique case (cmd)
          CMD_BOX_MIN: begin min_x_q <= ix; min_y_q <= iy; min_z_q <= iz; end
          CMD_FRAME:   off_q <= '0;
          CMD_CULL: begin
            idx_q <= '0; cnt_q <= '0;
            limit_q <= (32'(count_q) > MAX_LIGHTS) ? IdxW'(MAX_LIGHTS) : IdxW'(count_q);
          end
          default: ;
        endcase
      end
      if (state_q == ST_READ) axis_q <= '0;
      if (state_q == ST_AXIS) axis_q <= axis_q + 2'd1;
      if (state_q == ST_TEST && state_d == ST_READ) idx_q <= idx_q + 1'b1;
      if (state_q == ST_EMIT && out_xfer) begin
        idx_q <= idx_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_SUM && out_xfer)
        off_q <= off_sum[OffsetW] ? OffsetMax : off_sum[OffsetW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      max_x_q <= ix; max_y_q <= iy; max_z_q <= iz;
    end
    if (state_q == ST_READ) acc_q <= '0;
    if (state_q == ST_AXIS) begin
      if (axis_q == 2'd3) rr_q <= sq;
      else acc_q <= sum[64] ? {1'b1, 64'd0} : sum;
    end
  end

  logic [SlotW-1:0] vis_idx;
  assign vis_idx = SlotW'(idx_q);
  assign m_axis_tvalid = (state_q == ST_EMIT) || (state_q == ST_SUM);
  assign m_axis_tuser  = (state_q == ST_SUM) ? RES_SUMMARY : RES_INDEX;
  assign m_axis_tlast  = (state_q == ST_SUM);
  assign m_axis_tdata  = (state_q == ST_SUM) ? {4'd0, cnt_q, off_q, 6'd0}
                                             : {34'd0, vis_idx};

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_PER_CLUSTER) else $error("count above cap");
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && !m_axis_tready) |=> state_q == ST_SUM)
    else $error("summary dropped");
`endif

endmodule

### tb/cluster_light_culler_tb.sv
`timescale 1ns / 100ps

module cluster_light_culler_tb;
  import clc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [23:0] offset;
    logic [5:0]  total;
    logic        last;
  } cull_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;

  cluster_light_culler uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial forever #2 clk_i = ~clk_i;

  logic signed [31:0] tbl_x [64];
  logic signed [31:0] tbl_y [64];
  logic signed [31:0] tbl_z [64];
  logic [30:0] tbl_range [64];
  logic tbl_dir [64];
  logic signed [31:0] bmin_x, bmin_y, bmin_z;
  logic [23:0] run_offset;
  logic [6:0] lights_tested;

  logic [143:0] pending_cmds [$];
  cull_result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 65;
  int hold_off = 0;

  function automatic logic [63:0] axis_dist_sq(logic signed [31:0] p,
                                                logic signed [31:0] lo,
                                                logic signed [31:0] hi);
    logic signed [33:0] c;
    logic signed [33:0] d;
    logic [32:0] a;
    c = p;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    d = p - c;
    a = d < 0 ? -d : d;
    return 64'(a) * 64'(a);
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic predict_culler(logic [143:0] d);
    cmd_e c;
    logic [5:0] sl;
    logic signed [31:0] x, y, z;
    logic [63:0] d2, r;
    int n, cnt;
    logic [24:0] s;
    cull_result_t res;
    c = cmd_e'(d[1:0]);
    sl = d[7:2];
    x = d[39:8];
    y = d[71:40];
    z = d[103:72];
    cnt = 0;
    case (c)
      CMD_LOAD_LIGHT: begin
        tbl_x[sl] = x;
        tbl_y[sl] = y;
        tbl_z[sl] = z;
        tbl_range[sl] = d[134:104];
        tbl_dir[sl] = (d[142:135] == 8'd0);
      end
      CMD_BOX_MIN: begin
        bmin_x = x;
        bmin_y = y;
        bmin_z = z;
      end
      CMD_FRAME: run_offset = '0;
      CMD_CULL: begin
        n = lights_tested > 64 ? 64 : lights_tested;
        for (int i = 0; i < n; i++) begin
          r = 64'(tbl_range[i]);
          d2 = sum_sat(sum_sat(axis_dist_sq(tbl_x[i], bmin_x, x),
                               axis_dist_sq(tbl_y[i], bmin_y, y)),
                       axis_dist_sq(tbl_z[i], bmin_z, z));
          if ((tbl_dir[i] || d2 <= r * r) && cnt < 32) begin
            res = '{RES_INDEX, 6'(i), 24'd0, 6'd0, 1'b0};
            expected_results = {expected_results, res};
            cnt++;
          end
        end
        res = '{RES_SUMMARY, 6'd0, run_offset, 6'(cnt), 1'b1};
        expected_results = {expected_results, res};
        s = 25'(run_offset + cnt);
        run_offset = s > OffsetMax ? OffsetMax : s[23:0];
      end
    endcase
  endtask

  function automatic logic [143:0] pack_cmd(cmd_e c, logic [5:0] sl, logic [31:0] x,
                                            logic [31:0] y, logic [31:0] z,
                                            logic [30:0] rad, logic [7:0] k);
    return {1'b0, k, rad, z, y, x, sl, c};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return 31'($urandom);
      1: return 31'h7fff_ffff;
      default: return 31'($urandom_range(0, 12 << 16));
    endcase
  endfunction

  task automatic queue_cmd(logic [143:0] d);
    pending_cmds = {pending_cmds, d};
  endtask

  task automatic drain_and_config(int cnt);
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lights_tested = 7'(cnt);
  endtask

  task automatic load_all_lights();
    for (int i = 0; i < 64; i++)
      queue_cmd(pack_cmd(CMD_LOAD_LIGHT, 6'(i), rand_coord(), rand_coord(), rand_coord(),
                         rand_radius(), $urandom_range(0, 9) == 0 ? 8'd0 : 8'($urandom)));
  endtask

  task automatic queue_random_cmds(int num);
    logic [31:0] lx, ly, lz;
    for (int i = 0; i < num; i++) begin
      case ($urandom_range(0, 9))
        0, 1: queue_cmd(pack_cmd(CMD_LOAD_LIGHT, 6'($urandom), rand_coord(), rand_coord(),
                                 rand_coord(), rand_radius(),
                                 $urandom_range(0, 5) == 0 ? 8'd0 : 8'($urandom)));
        2: queue_cmd(pack_cmd(CMD_FRAME, 6'($urandom), $urandom, $urandom, $urandom,
                              31'($urandom), 8'($urandom)));
        default: begin
          lx = rand_coord();
          ly = rand_coord();
          lz = rand_coord();
          queue_cmd(pack_cmd(CMD_BOX_MIN, 6'($urandom), lx, ly, lz, 31'($urandom),
                             8'($urandom)));
          if ($urandom_range(0, 4) != 0) begin
            lx = lx + $urandom_range(0, 8 << 16);
            ly = ly + $urandom_range(0, 8 << 16);
            lz = lz + $urandom_range(0, 8 << 16);
          end else begin
            lx = rand_coord();
            ly = rand_coord();
            lz = rand_coord();
          end
          queue_cmd(pack_cmd(CMD_CULL, 6'($urandom), lx, ly, lz, 31'($urandom),
                             8'($urandom)));
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) predict_culler(s_axis_tdata);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata <= pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk_i) begin
    cull_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tdata[35:30],
              m_axis_tlast};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    m_axis_tready <= rst_ni && (hold_off == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bmin_x = 0;
    bmin_y = 0;
    bmin_z = 0;
    run_offset = '0;
    lights_tested = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_all_lights();
    queue_cmd(pack_cmd(CMD_CULL, 6'd0, 32'd0, 32'd0, 32'd0, 31'd0, 8'd0));
    drain_and_config(64);
    queue_cmd(pack_cmd(CMD_LOAD_LIGHT, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       31'h7fff_ffff, 8'hff));
    queue_cmd(pack_cmd(CMD_LOAD_LIGHT, 6'd63, 32'd0, 32'd0, 32'd0, 31'd0, 8'd0));
    queue_cmd(pack_cmd(CMD_LOAD_LIGHT, 6'd1, 32'd0, 32'd0, 32'd0, 31'd0, 8'd1));
    queue_cmd(pack_cmd(CMD_BOX_MIN, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       31'd0, 8'd0));
    queue_cmd(pack_cmd(CMD_CULL, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       31'd0, 8'd0));
    queue_cmd(pack_cmd(CMD_BOX_MIN, 6'h3f, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                       31'h7fff_ffff, 8'hff));
    queue_cmd(pack_cmd(CMD_CULL, 6'h3f, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       31'h7fff_ffff, 8'hff));
    queue_cmd(pack_cmd(CMD_FRAME, 6'h3f, '1, '1, '1, '1, 8'hff));
    queue_cmd(pack_cmd(CMD_CULL, 6'd0, 32'd0, 32'd0, 32'd0, 31'd0, 8'd0));
    drain_and_config(127);
    queue_cmd(pack_cmd(CMD_CULL, 6'd0, '1, '1, '1, 31'd0, 8'd0));
    hold_off = 600;
    queue_random_cmds(12);
    drain_and_config(5);
    queue_random_cmds(52);
    drain_and_config(40);
    send_idle_pct = 65;
    recv_idle_pct = 16;
    queue_random_cmds(52);
    drain_and_config(1);
    queue_random_cmds(44);
    drain_and_config(64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_cmds(48);
    drain_and_config(20);
    queue_random_cmds(30);
    drain_and_config(0);

    while (pending_cmds.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/clc_pkg.sv
rtl/cluster_light_culler.sv
tb/cluster_light_culler_tb.sv
